[rtl/go_to_goal_controller_defines.svh]
// Assertion macros used by the checker file of the go-to-goal controller.
// They expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef GO_TO_GOAL_CONTROLLER_DEFINES_SVH
`define GO_TO_GOAL_CONTROLLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GGC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GGC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ggc_pkg.sv]
package ggc_pkg;

	// Field and register widths.
	localparam int POS_W   = 16;
	localparam int HEAD_W  = 15;
	localparam int STOP_W  = 15;
	localparam int GAIN_W  = 10;
	localparam int SPEED_W = 15;
	localparam int TURN_W  = 15;
	localparam int CFG_W   = 16;
	localparam int RIDX_W  = 2;

	// Difference of two positions, one bit wider than a position.
	localparam int DIFF_W = POS_W + 1;

	// CORDIC datapath: the vector is the difference scaled by 2^24, plus growth headroom.
	localparam int PRE_SHIFT = 24;
	localparam int XW        = 44;
	localparam int ZW        = 34;
	localparam int ATAN_LEN  = 24;
	localparam int ATAN_IW   = 5;

	localparam int CORDIC_STEPS_DEF = 16;

	// Register indexes on the write port.
	localparam logic [RIDX_W-1:0] REG_TARGET_X = 2'd0;
	localparam logic [RIDX_W-1:0] REG_TARGET_Y = 2'd1;
	localparam logic [RIDX_W-1:0] REG_STOP     = 2'd2;
	localparam logic [RIDX_W-1:0] REG_GAIN     = 2'd3;

	// Register values after reset.
	localparam logic signed [POS_W-1:0] TARGET_X_RST = 16'sd2048;
	localparam logic signed [POS_W-1:0] TARGET_Y_RST = 16'sd2048;
	localparam logic [STOP_W-1:0]       STOP_RST     = 15'd102;
	localparam logic [GAIN_W-1:0]       GAIN_RST     = 10'd128;

	// Angle constants.
	localparam int PI_Q12     = 12868;
	localparam int TWO_PI_Q12 = 25736;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

	// Reciprocal of the CORDIC gain in Q.30.
	localparam int INV_W = 31;
	localparam logic signed [INV_W-1:0] INV_GAIN_Q30 = 31'sh26DD3B6A;

	// atan(2^-i) in Q.30, truncated.
	localparam logic signed [ZW-1:0] ATAN_Q30 [ATAN_LEN] = '{
		34'sh3243F6A8, 34'sh1DAC6705, 34'sh0FADBAFC, 34'sh07F56EA6,
		34'sh03FEAB76, 34'sh01FFD55B, 34'sh00FFFAAA, 34'sh007FFF55,
		34'sh003FFFEA, 34'sh001FFFFD, 34'sh000FFFFF, 34'sh0007FFFF,
		34'sh0003FFFF, 34'sh0001FFFF, 34'sh0000FFFF, 34'sh00007FFF,
		34'sh00003FFF, 34'sh00001FFF, 34'sh00000FFF, 34'sh000007FF,
		34'sh000003FF, 34'sh000001FF, 34'sh000000FF, 34'sh0000007F
	};

	// Final vector of a vectoring pass: scaled magnitude and accumulated angle.
	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [ZW-1:0] z;
	} ggc_vec_t;

endpackage

[rtl/ggc_in_if.sv]
interface ggc_in_if;
	import ggc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     cmd;
	logic signed [POS_W-1:0]  pose_x;
	logic signed [POS_W-1:0]  pose_y;
	logic signed [HEAD_W-1:0] pose_heading;

	modport source (output valid, cmd, pose_x, pose_y, pose_heading, input ready);
	modport sink (input valid, cmd, pose_x, pose_y, pose_heading, output ready);
endinterface

[rtl/ggc_out_if.sv]
interface ggc_out_if;
	import ggc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [SPEED_W-1:0]       linear_speed;
	logic signed [TURN_W-1:0] turn_rate;

	modport source (output valid, linear_speed, turn_rate, input ready);
	modport sink (input valid, linear_speed, turn_rate, output ready);
endinterface

[rtl/ggc_cordic.sv]
module ggc_cordic #(
	parameter int CORDIC_STEPS = ggc_pkg::CORDIC_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [ggc_pkg::DIFF_W-1:0] dx,
	input  logic signed [ggc_pkg::DIFF_W-1:0] dy,
	output logic                              done,
	output ggc_pkg::ggc_vec_t                 vec
);
	import ggc_pkg::*;

	localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam logic [CW-1:0] LAST = CW'(CORDIC_STEPS - 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;

	logic signed [XW-1:0] x0, y0;
	logic signed [XW-1:0] xs, ys;
	logic signed [ZW-1:0] atan_c;

	// Scale the differences up to the CORDIC fixed point.
	assign x0 = XW'($signed({dx, {PRE_SHIFT{1'b0}}}));
	assign y0 = XW'($signed({dy, {PRE_SHIFT{1'b0}}}));

	// Shared shift and table lookup for the current iteration.
	assign xs     = x_q >>> cnt_q;
	assign ys     = y_q >>> cnt_q;
	assign atan_c = ATAN_Q30[ATAN_IW'(cnt_q)];

	// Sequencer: one micro-rotation per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	// Vector and angle registers, with the quarter turn for a vector in the left half.
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			if (!x0[XW-1]) begin
				x_q <= x0;
				y_q <= y0;
				z_q <= '0;
			end else if (!y0[XW-1]) begin
				x_q <= y0;
				y_q <= -x0;
				z_q <= HALF_PI_Q30;
			end else begin
				x_q <= -y0;
				y_q <= x0;
				z_q <= -HALF_PI_Q30;
			end
		end else if (busy_q) begin
			if (!y_q[XW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_c;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_c;
			end
		end
	end

	assign done  = done_q;
	assign vec.x = x_q;
	assign vec.z = z_q;

endmodule

[rtl/go_to_goal_controller.sv]
// A pose word is stored and the block stays ready.
// A control tick with a stored pose runs the CORDIC, distance and speed steps until the
// result word is offered, and the input is not ready meanwhile.
// The CORDIC has a single add/shift stage, reused once per iteration.
// A tick with no stored pose is taken and gives no word.
// Reset (arst_n low, asynchronous) clears the stored pose and loads the register defaults.
module go_to_goal_controller #(
	parameter int CORDIC_STEPS = ggc_pkg::CORDIC_STEPS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	ggc_in_if.sink                           item,
	ggc_out_if.source                        result,
	input  logic                             wr_en,
	input  logic [ggc_pkg::RIDX_W-1:0]       wr_index,
	input  logic [ggc_pkg::CFG_W-1:0]        wr_data
);
	import ggc_pkg::*;

	localparam int XSH_W  = XW - 12;
	localparam int PROD_W = XSH_W + INV_W;
	localparam int DIST_W = 20;
	localparam int DS_W   = PROD_W - 42;
	localparam int BEAR_W = ZW - 18;
	localparam int ERR_W  = BEAR_W + 1;
	localparam int SP_W   = DIST_W + GAIN_W;

	localparam logic signed [PROD_W-1:0] DIST_RND = PROD_W'(64'sd1 <<< 41);
	localparam logic signed [ZW-1:0]     BEAR_RND = ZW'(64'sd1 <<< 17);
	localparam logic signed [ERR_W-1:0]  PI_E     = ERR_W'(PI_Q12);
	localparam logic signed [ERR_W-1:0]  TWO_PI_E = ERR_W'(TWO_PI_Q12);
	localparam logic [SP_W:0]            SP_RND   = (SP_W + 1)'(128);
	localparam logic [SP_W-8:0]          SP_MAX   = (SP_W - 7)'(32767);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_DIST,
		ST_SPEED,
		ST_OUT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic signed [POS_W-1:0] target_x_q, target_y_q;
	logic [STOP_W-1:0]       stop_q;
	logic [GAIN_W-1:0]       gain_q;

	// Stored pose.
	logic signed [POS_W-1:0]  stored_x_q, stored_y_q;
	logic signed [HEAD_W-1:0] stored_hd_q;
	logic                     pose_valid_q;

	// Datapath registers.
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ZW-1:0]     ang_q;
	logic [DIST_W-1:0]        dist_q;
	logic                     stop_hit_q;
	logic [TURN_W-1:0]        err_q;
	logic [SP_W-1:0]          sp_prod_q;

	// Output register.
	logic                     out_valid_q;
	logic [SPEED_W-1:0]       out_speed_q;
	logic [TURN_W-1:0]        out_turn_q;

	logic                     accept;
	logic                     cordic_start;
	logic                     cordic_done;
	ggc_vec_t                 vec;
	logic signed [DIFF_W-1:0] dx, dy;
	logic signed [XSH_W-1:0]  xsh;
	logic signed [PROD_W-1:0] prod_c;
	logic signed [PROD_W-1:0] prod_rnd;
	logic signed [DS_W-1:0]   dist_s;
	logic [DIST_W-1:0]        dist_c;
	logic signed [ZW-1:0]     ang_rnd;
	logic signed [BEAR_W-1:0] bearing;
	logic signed [ERR_W-1:0]  err_raw, err_wrap;
	logic [SP_W:0]            sp_sum;
	logic [SP_W-8:0]          sp_sh;
	logic [SPEED_W-1:0]       speed_c;
	logic                     out_free;

	assign item.ready   = (state_q == ST_IDLE);
	assign accept       = item.valid && item.ready;
	assign cordic_start = accept && item.cmd && pose_valid_q;
	assign out_free     = !out_valid_q || result.ready;

	// Vector from the stored pose to the goal.
	assign dx = DIFF_W'(target_x_q) - DIFF_W'(stored_x_q);
	assign dy = DIFF_W'(target_y_q) - DIFF_W'(stored_y_q);

	ggc_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cordic_start),
		.dx    (dx),
		.dy    (dy),
		.done  (cordic_done),
		.vec   (vec)
	);

	// Gain correction of the CORDIC magnitude.
	assign xsh    = $signed(vec.x[XW-1:12]);
	assign prod_c = xsh * INV_GAIN_Q30;

	// Distance in Q10.10, rounded and clamped at zero.
	assign prod_rnd = prod_q + DIST_RND;
	assign dist_s   = prod_rnd[PROD_W-1:42];
	assign dist_c   = dist_s[DS_W-1] ? '0 : dist_s[DIST_W-1:0];

	// Bearing in Q3.12 and the heading error, wrapped once.
	assign ang_rnd = ang_q + BEAR_RND;
	assign bearing = ang_rnd[ZW-1:18];
	assign err_raw = ERR_W'(bearing) - ERR_W'(stored_hd_q);

	always_comb begin
		if (err_raw > PI_E) begin
			err_wrap = err_raw - TWO_PI_E;
		end else if (err_raw < -PI_E) begin
			err_wrap = err_raw + TWO_PI_E;
		end else begin
			err_wrap = err_raw;
		end
	end

	// Speed: rounded product, saturated.
	assign sp_sum  = (SP_W + 1)'(sp_prod_q) + SP_RND;
	assign sp_sh   = sp_sum[SP_W:8];
	assign speed_c = (sp_sh > SP_MAX) ? SPEED_W'(32767) : sp_sh[SPEED_W-1:0];

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q <= TARGET_X_RST;
			target_y_q <= TARGET_Y_RST;
			stop_q     <= STOP_RST;
			gain_q     <= GAIN_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_TARGET_X: target_x_q <= $signed(wr_data[POS_W-1:0]);
				REG_TARGET_Y: target_y_q <= $signed(wr_data[POS_W-1:0]);
				REG_STOP:     stop_q     <= wr_data[STOP_W-1:0];
				REG_GAIN:     gain_q     <= wr_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Pose store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_x_q   <= '0;
			stored_y_q   <= '0;
			stored_hd_q  <= '0;
			pose_valid_q <= 1'b0;
		end else if (accept && !item.cmd) begin
			stored_x_q   <= item.pose_x;
			stored_y_q   <= item.pose_y;
			stored_hd_q  <= item.pose_heading;
			pose_valid_q <= 1'b1;
		end
	end

	// Datapath registers along the sequence.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_CORDIC: begin
				if (cordic_done) begin
					prod_q <= prod_c;
					ang_q  <= vec.z;
				end
			end
			ST_DIST: begin
				dist_q     <= dist_c;
				stop_hit_q <= (dist_c <= DIST_W'(stop_q));
				err_q      <= err_wrap[TURN_W-1:0];
			end
			ST_SPEED: begin
				sp_prod_q <= dist_q * gain_q;
			end
			default: begin
			end
		endcase
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_speed_q <= '0;
			out_turn_q  <= '0;
		end else begin
			// The output register loads a new word or drops one that was taken.
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
				out_speed_q <= stop_hit_q ? '0 : speed_c;
				out_turn_q  <= stop_hit_q ? '0 : err_q;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cordic_start) begin
						state_q <= ST_CORDIC;
					end
				end
				ST_CORDIC: begin
					if (cordic_done) begin
						state_q <= ST_DIST;
					end
				end
				ST_DIST: begin
					state_q <= ST_SPEED;
				end
				ST_SPEED: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid        = out_valid_q;
	assign result.linear_speed = out_speed_q;
	assign result.turn_rate    = $signed(out_turn_q);

endmodule

[rtl/ggc_checker.sv]
`include "go_to_goal_controller_defines.svh"

module ggc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             in_cmd,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [ggc_pkg::SPEED_W-1:0]      out_speed,
	input logic signed [ggc_pkg::TURN_W-1:0] out_turn
);
	import ggc_pkg::*;

	// A pose word is stored at once and leaves the input ready.
	`GGC_ASSERT_NEXT(a_pose_keeps_ready, in_valid && in_ready && !in_cmd, in_ready, "ready dropped after a pose word")

	// A tick never produces its result in the very next cycle.
	`GGC_ASSERT_NEXT(a_tick_no_instant_result, in_valid && in_ready && in_cmd, !$rose(out_valid), "result appeared one cycle after a tick")

	// The wrapped heading error always lies within plus or minus pi.
	`GGC_ASSERT_NOW(a_turn_in_range, out_valid, (out_turn <= PI_Q12) && (out_turn >= -PI_Q12), "turn rate beyond pi")

	// A result that is not taken stays offered and unchanged.
	`GGC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_speed) && $stable(out_turn), "stalled result changed")

endmodule

bind go_to_goal_controller ggc_checker u_ggc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (item.valid),
	.in_ready (item.ready),
	.in_cmd   (item.cmd),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_speed(result.linear_speed),
	.out_turn (result.turn_rate)
);
